// File: hdl/llss_pkg.sv
// Package for the least-loaded server scheduler.
// Holds field widths, mode codes and the controller/datapath command and status types.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package llss_pkg;

   localparam int MAX_SERVERS_DEF = 16;

   localparam int MODE_W    = 2;
   localparam int PORT_IDX_W = 4;
   localparam int RATE_W    = 8;
   localparam int ITEMS_W   = 8;
   localparam int BUSY_W    = 32;
   localparam int CNT_W     = 5;
   localparam int PROD_W    = RATE_W + ITEMS_W;

   localparam logic [CNT_W-1:0] CNT_RESET = 5'd16;

   localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_JOB   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

   typedef struct packed {
      logic load_rate;
      logic clear_batch;
      logic start_job;
      logic scan_read;
      logic read_rate;
      logic multiply;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic scan_end;
      logic slot_free;
   } status_type;

endpackage

// File: hdl/llss_if.sv
// Valid/ready channel interfaces for the scheduler's request and response sides.
// Depends on llss_pkg for the field widths.
`timescale 1ns / 1ps

interface llss_req_if;
   import llss_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [MODE_W-1:0]     mode;
   logic [PORT_IDX_W-1:0] server_index;
   logic [RATE_W-1:0]     rate;
   logic [ITEMS_W-1:0]    item_count;
   logic                  last;

   modport source (output valid, mode, server_index, rate, item_count, last, input ready);
   modport sink   (input valid, mode, server_index, rate, item_count, last, output ready);
endinterface

interface llss_rsp_if;
   import llss_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [PORT_IDX_W-1:0] chosen_server;
   logic [BUSY_W-1:0]     finish_time;
   logic [BUSY_W-1:0]     makespan;
   logic                  final_res;

   modport source (output valid, chosen_server, finish_time, makespan, final_res, input ready);
   modport sink   (input valid, chosen_server, finish_time, makespan, final_res, output ready);
endinterface

// File: hdl/least_loaded_server_scheduler.sv
// Least-loaded server scheduler: a job scans the busy times of the n active servers,
// then reads the rate, multiplies and commits; the commit waits for a free response slot.
// The scan reads one busy time per cycle from the busy-time memory.
// Rate loads and batch clears return nothing.
// Reset clears all busy times (through valid bits) and the makespan, and sets the
// server count to sixteen; server rates are undefined until loaded.
`timescale 1ns / 1ps

module least_loaded_server_scheduler #(
   parameter int MAX_SERVERS = llss_pkg::MAX_SERVERS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   llss_req_if.sink                  req_bus,
   llss_rsp_if.source                rsp_bus,
   input  logic                      csr_we,
   input  logic [llss_pkg::CNT_W-1:0] csr_wdata
);
   import llss_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       req_ready;

   assign req_bus.ready = req_ready;

   llss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_mode  (req_bus.mode),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   llss_dp #(
      .MAX_SERVERS (MAX_SERVERS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .req_server_index (req_bus.server_index),
      .req_rate         (req_bus.rate),
      .req_item_count   (req_bus.item_count),
      .req_last         (req_bus.last),
      .cmd              (cmd),
      .status           (status),
      .rsp_bus          (rsp_bus)
   );

endmodule

// File: hdl/llss_ctrl.sv
// Controller state machine of the scheduler: request handshake and job sequencing.
// Depends on llss_pkg for the command and status types and the mode codes.
`timescale 1ns / 1ps

module llss_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic [llss_pkg::MODE_W-1:0] req_mode,
   output logic                       req_ready,
   input  llss_pkg::status_type       status,
   output llss_pkg::cmd_type          cmd
);
   import llss_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SETTLE,
      S_RATE,
      S_MUL,
      S_COMMIT
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;
   logic      accept;

   assign accept    = req_valid && ready_ff;
   assign req_ready = ready_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_mode)
                  MODE_LOAD:  cmd.load_rate = 1'b1;
                  MODE_CLEAR: cmd.clear_batch = 1'b1;
                  MODE_JOB: begin
                     cmd.start_job = 1'b1;
                     state_in      = S_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         S_SCAN: begin
            cmd.scan_read = 1'b1;
            if (status.scan_end) begin
               state_in = S_SETTLE;
            end
         end
         // The compare of the last busy time read lands at this edge.
         S_SETTLE: state_in = S_RATE;
         S_RATE: begin
            cmd.read_rate = 1'b1;
            state_in      = S_MUL;
         end
         S_MUL: begin
            cmd.multiply = 1'b1;
            state_in     = S_COMMIT;
         end
         S_COMMIT: begin
            if (status.slot_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      ready_in = (state_in == S_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

endmodule

// File: hdl/llss_dp.sv
// Datapath of the scheduler: rate and busy-time memories, minimum scan,
// multiply-accumulate with saturation, makespan and the response register.
// Depends on llss_pkg and the llss_rsp_if interface.
`timescale 1ns / 1ps

module llss_dp #(
   parameter int MAX_SERVERS = llss_pkg::MAX_SERVERS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [llss_pkg::CNT_W-1:0]      csr_wdata,
   input  logic [llss_pkg::PORT_IDX_W-1:0] req_server_index,
   input  logic [llss_pkg::RATE_W-1:0]     req_rate,
   input  logic [llss_pkg::ITEMS_W-1:0]    req_item_count,
   input  logic                           req_last,
   input  llss_pkg::cmd_type              cmd,
   output llss_pkg::status_type           status,
   llss_rsp_if.source                     rsp_bus
);
   import llss_pkg::*;

   // Only sixteen servers are addressable through the four-bit index.
   localparam int DEPTH = (MAX_SERVERS < 16) ? MAX_SERVERS : 16;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   logic [RATE_W-1:0] rate_mem [DEPTH];
   logic [BUSY_W-1:0] busy_mem [DEPTH];
   logic [DEPTH-1:0]  busy_vld_ff;

   logic [CNT_W-1:0]   csr_count_ff;
   logic [CNT_W-1:0]   n_ff, n_in;
   logic [ITEMS_W-1:0] items_ff;
   logic               last_ff;
   logic [IDX_W-1:0]   scan_addr_ff;
   logic [BUSY_W-1:0]  busy_rd_ff;
   logic [IDX_W-1:0]   rd_idx_ff;
   logic               rd_vld_ff;
   logic               first_ff;
   logic [IDX_W-1:0]   best_idx_ff;
   logic [BUSY_W-1:0]  best_busy_ff;
   logic [RATE_W-1:0]  rate_rd_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic [BUSY_W-1:0]  max_ff, max_in;
   logic [BUSY_W:0]    sum;
   logic [BUSY_W-1:0]  sat;
   logic               take;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PORT_IDX_W-1:0] rsp_server_ff;
   logic [BUSY_W-1:0]     rsp_finish_ff;
   logic [BUSY_W-1:0]     rsp_makespan_ff;
   logic                  rsp_final_ff;

   // A count of zero means one server; a count above the depth is clipped.
   always_comb begin
      n_in = csr_count_ff;
      if (csr_count_ff == '0) begin
         n_in = CNT_W'(1);
      end else if (csr_count_ff > DEPTH_CNT) begin
         n_in = DEPTH_CNT;
      end
   end

   assign status.scan_end  = (CNT_W'(scan_addr_ff) + CNT_W'(1)) == n_ff;
   assign status.slot_free = !rsp_valid_ff || rsp_bus.ready;

   assign take = rd_vld_ff && (first_ff || (busy_rd_ff < best_busy_ff));

   assign sum    = {1'b0, best_busy_ff} + (BUSY_W + 1)'(prod_ff);
   assign sat    = sum[BUSY_W] ? '1 : sum[BUSY_W-1:0];
   assign max_in = (sat > max_ff) ? sat : max_ff;

   assign rsp_valid_in = cmd.commit ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_count_ff <= CNT_RESET;
      end else if (csr_we) begin
         csr_count_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rate && (CNT_W'(req_server_index) < DEPTH_CNT)) begin
         rate_mem[req_server_index[IDX_W-1:0]] <= req_rate;
      end
      if (cmd.read_rate) begin
         rate_rd_ff <= rate_mem[best_idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         busy_mem[best_idx_ff] <= sat;
      end
      if (cmd.scan_read) begin
         busy_rd_ff <= busy_vld_ff[scan_addr_ff] ? busy_mem[scan_addr_ff] : '0;
         rd_idx_ff  <= scan_addr_ff;
      end
   end

   // Valid bits stand in for clearing the busy-time memory.
   always_ff @(posedge clock) begin
      if (reset || cmd.clear_batch) begin
         busy_vld_ff <= '0;
         max_ff      <= '0;
      end else if (cmd.commit) begin
         busy_vld_ff[best_idx_ff] <= 1'b1;
         max_ff                   <= max_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff    <= 1'b0;
         first_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_vld_ff    <= cmd.scan_read;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.start_job) begin
            first_ff <= 1'b1;
         end else if (rd_vld_ff) begin
            first_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_job) begin
         n_ff         <= n_in;
         items_ff     <= req_item_count;
         last_ff      <= req_last;
         scan_addr_ff <= '0;
      end else if (cmd.scan_read) begin
         scan_addr_ff <= scan_addr_ff + IDX_W'(1);
      end
      if (take) begin
         best_idx_ff  <= rd_idx_ff;
         best_busy_ff <= busy_rd_ff;
      end
      if (cmd.multiply) begin
         prod_ff <= PROD_W'(items_ff) * PROD_W'(rate_rd_ff);
      end
      if (cmd.commit) begin
         rsp_server_ff   <= PORT_IDX_W'(best_idx_ff);
         rsp_finish_ff   <= sat;
         rsp_makespan_ff <= max_in;
         rsp_final_ff    <= last_ff;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.chosen_server = rsp_server_ff;
   assign rsp_bus.finish_time   = rsp_finish_ff;
   assign rsp_bus.makespan      = rsp_makespan_ff;
   assign rsp_bus.final_res     = rsp_final_ff;

   a_makespan_covers_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_makespan_ff >= rsp_finish_ff))
      else $error("makespan below finish time of the pending response");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_read |-> (CNT_W'(scan_addr_ff) < n_ff))
      else $error("scan address beyond the active server count");

   a_best_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (CNT_W'(best_idx_ff) < n_ff))
      else $error("chosen server beyond the active server count");

   a_commit_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp_bus.ready))
      else $error("response overwritten before its transfer");

endmodule
